// File: src/qrs_pkg.sv
// Shared types and constants for the quadratic root solver.
`timescale 1ns / 1ps
package qrs_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_DISTINCT = 2'd0;
    localparam kind_t KIND_EQUAL    = 2'd1;
    localparam kind_t KIND_COMPLEX  = 2'd2;
    localparam kind_t KIND_LINEAR   = 2'd3;

    localparam int ROOT_WIDTH  = 34;
    localparam int QUEUE_DEPTH = 4;

    typedef logic signed [ROOT_WIDTH-1:0] root_t;

    // Clamp a wide signed root part to the output range
    function automatic root_t sat_root(input logic signed [63:0] v);
        logic signed [63:0] hi_lim;
        logic signed [63:0] lo_lim;
        hi_lim = (64'sd1 <<< (ROOT_WIDTH - 1)) - 64'sd1;
        lo_lim = -(64'sd1 <<< (ROOT_WIDTH - 1));
        if (v > hi_lim)
        begin
            sat_root = hi_lim[ROOT_WIDTH-1:0];
        end
        else if (v < lo_lim)
        begin
            sat_root = lo_lim[ROOT_WIDTH-1:0];
        end
        else
        begin
            sat_root = v[ROOT_WIDTH-1:0];
        end
    endfunction

endpackage

// File: src/qrs_front.sv
// Front end: accept coefficients, form the discriminant and classify the roots.
`timescale 1ns / 1ps
module qrs_front #(
    parameter int COEF_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COEF_WIDTH-1:0]  coef_a,
    input  logic signed [COEF_WIDTH-1:0]  coef_b,
    input  logic signed [COEF_WIDTH-1:0]  coef_c,
    output logic                          push,
    input  logic                          full,
    output qrs_pkg::kind_t                push_kind,
    output logic [2*COEF_WIDTH:0]         push_dmag,
    output logic signed [COEF_WIDTH-1:0]  push_a,
    output logic signed [COEF_WIDTH-1:0]  push_b
);
    import qrs_pkg::*;

    localparam int PW = 2 * COEF_WIDTH;
    localparam int DW = 2 * COEF_WIDTH + 1;
    localparam int SW = 2 * COEF_WIDTH + 3;

    logic                         valid_reg;
    logic signed [PW-1:0]         bsq_reg;
    logic signed [PW-1:0]         ac_reg;
    logic signed [COEF_WIDTH-1:0] a_reg;
    logic signed [COEF_WIDTH-1:0] b_reg;
    logic                         load;
    logic signed [SW-1:0]         disc;
    logic signed [SW-1:0]         disc_mag;
    logic                         disc_neg;

    assign in_stall = valid_reg && full;
    assign load     = in_valid && !in_stall;
    assign push     = valid_reg && !full;

    // Track the held word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Register the two products
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            bsq_reg <= PW'(coef_b) * PW'(coef_b);
            ac_reg  <= PW'(coef_a) * PW'(coef_c);
            a_reg   <= coef_a;
            b_reg   <= coef_b;
        end
    end

    // Form b*b - 4ac and its magnitude
    always_comb
    begin
        disc     = SW'(bsq_reg) - (SW'(ac_reg) <<< 2);
        disc_neg = disc[SW-1];
        disc_mag = disc_neg ? -disc : disc;
    end

    assign push_dmag = disc_mag[DW-1:0];
    assign push_a    = a_reg;
    assign push_b    = b_reg;

    // Classify the root pair
    always_comb
    begin
        if (a_reg == '0)
        begin
            push_kind = KIND_LINEAR;
        end
        else if (disc_neg)
        begin
            push_kind = KIND_COMPLEX;
        end
        else if (disc == '0)
        begin
            push_kind = KIND_EQUAL;
        end
        else
        begin
            push_kind = KIND_DISTINCT;
        end
    end

endmodule

// File: src/qrs_queue.sv
// Small FIFO between the front end and the arithmetic back end.
`timescale 1ns / 1ps
module qrs_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);
    import qrs_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]    head_reg;
    logic [AW-1:0]    tail_reg;
    logic [AW:0]      count_reg;

    assign full    = (count_reg == (AW+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[head_reg];

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                tail_reg <= tail_reg + 1'b1;
            end
            if (rd_en)
            begin
                head_reg <= head_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[tail_reg] <= wr_data;
        end
    end

endmodule

// File: src/qrs_sqrt.sv
// Pipelined floor square root, one result bit per stage.
`timescale 1ns / 1ps
module qrs_sqrt #(
    parameter int XW  = 66,
    parameter int SBW = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [XW-1:0]     x,
    input  logic [SBW-1:0]    sb_in,
    output logic              out_valid,
    output logic [XW/2-1:0]   root,
    output logic [SBW-1:0]    sb_out
);
    localparam int N = XW / 2;

    logic            vld_reg  [N];
    logic [N+1:0]    rem_reg  [N];
    logic [N-1:0]    root_reg [N];
    logic [XW-1:0]   x_reg    [N];
    logic [SBW-1:0]  sb_reg   [N];

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_stage
            logic           v_in;
            logic [N+1:0]   r_in;
            logic [N-1:0]   q_in;
            logic [XW-1:0]  x_in;
            logic [SBW-1:0] s_in;
            logic [N+1:0]   cat;
            logic [N+1:0]   trial;
            logic           ge;

            if (i == 0)
            begin : g_first
                assign v_in = in_valid;
                assign r_in = '0;
                assign q_in = '0;
                assign x_in = x;
                assign s_in = sb_in;
            end
            else
            begin : g_next
                assign v_in = vld_reg[i-1];
                assign r_in = rem_reg[i-1];
                assign q_in = root_reg[i-1];
                assign x_in = x_reg[i-1];
                assign s_in = sb_reg[i-1];
            end

            // Try the next root bit
            always_comb
            begin
                cat   = {r_in[N-1:0], x_in[XW-1:XW-2]};
                trial = {q_in, 2'b01};
                ge    = (cat >= trial);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i]  <= ge ? (cat - trial) : cat;
                    root_reg[i] <= {q_in[N-2:0], ge};
                    x_reg[i]    <= x_in << 2;
                    sb_reg[i]   <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[N-1];
    assign root      = root_reg[N-1];
    assign sb_out    = sb_reg[N-1];

endmodule

// File: src/qrs_div.sv
// Pipelined two-lane unsigned restoring divider with a shared divisor.
`timescale 1ns / 1ps
module qrs_div #(
    parameter int NW  = 35,
    parameter int DVW = 17,
    parameter int SBW = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   num_p,
    input  logic [NW-1:0]   num_q,
    input  logic [DVW-1:0]  divisor,
    input  logic [SBW-1:0]  sb_in,
    output logic            out_valid,
    output logic [NW-1:0]   quo_p,
    output logic [NW-1:0]   quo_q,
    output logic [SBW-1:0]  sb_out
);
    logic            vld_reg [NW];
    logic [DVW:0]    rp_reg  [NW];
    logic [DVW:0]    rq_reg  [NW];
    logic [NW-1:0]   np_reg  [NW];
    logic [NW-1:0]   nq_reg  [NW];
    logic [DVW-1:0]  d_reg   [NW];
    logic [SBW-1:0]  sb_reg  [NW];

    genvar i;
    generate
        for (i = 0; i < NW; i++)
        begin : g_stage
            logic           v_in;
            logic [DVW:0]   rp_in;
            logic [DVW:0]   rq_in;
            logic [NW-1:0]  np_in;
            logic [NW-1:0]  nq_in;
            logic [DVW-1:0] d_in;
            logic [SBW-1:0] s_in;
            logic [DVW:0]   cat_p;
            logic [DVW:0]   cat_q;
            logic [DVW:0]   d_ext;
            logic           ge_p;
            logic           ge_q;

            if (i == 0)
            begin : g_first
                assign v_in  = in_valid;
                assign rp_in = '0;
                assign rq_in = '0;
                assign np_in = num_p;
                assign nq_in = num_q;
                assign d_in  = divisor;
                assign s_in  = sb_in;
            end
            else
            begin : g_next
                assign v_in  = vld_reg[i-1];
                assign rp_in = rp_reg[i-1];
                assign rq_in = rq_reg[i-1];
                assign np_in = np_reg[i-1];
                assign nq_in = nq_reg[i-1];
                assign d_in  = d_reg[i-1];
                assign s_in  = sb_reg[i-1];
            end

            // Bring down one numerator bit and trial-subtract
            always_comb
            begin
                d_ext = {1'b0, d_in};
                cat_p = {rp_in[DVW-1:0], np_in[NW-1]};
                cat_q = {rq_in[DVW-1:0], nq_in[NW-1]};
                ge_p  = (cat_p >= d_ext);
                ge_q  = (cat_q >= d_ext);
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= v_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rp_reg[i] <= ge_p ? (cat_p - d_ext) : cat_p;
                    rq_reg[i] <= ge_q ? (cat_q - d_ext) : cat_q;
                    np_reg[i] <= {np_in[NW-2:0], ge_p};
                    nq_reg[i] <= {nq_in[NW-2:0], ge_q};
                    d_reg[i]  <= d_in;
                    sb_reg[i] <= s_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NW-1];
    assign quo_p     = np_reg[NW-1];
    assign quo_q     = nq_reg[NW-1];
    assign sb_out    = sb_reg[NW-1];

endmodule

// File: src/quadratic_root_solver_unit.sv
// Top level: front end, word queue and square-root / divide back end.
// Throughput: one word per cycle while the output is not stalled; the square root and
// divider are one-bit-per-stage pipelines.
// A four-word queue lets the front end keep accepting while the output is stalled.
// Reset (rst_n, asynchronous, active low) clears all valid flags and queue pointers.
`timescale 1ns / 1ps
module quadratic_root_solver_unit #(
    parameter int COEF_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COEF_WIDTH-1:0]  coef_a,
    input  logic signed [COEF_WIDTH-1:0]  coef_b,
    input  logic signed [COEF_WIDTH-1:0]  coef_c,
    output logic                          out_valid,
    input  logic                          out_stall,
    output qrs_pkg::kind_t                root_kind,
    output qrs_pkg::root_t                first_real,
    output qrs_pkg::root_t                first_imag,
    output qrs_pkg::root_t                second_real,
    output qrs_pkg::root_t                second_imag
);
    import qrs_pkg::*;

    localparam int CW  = COEF_WIDTH;
    localparam int DW  = 2 * CW + 1;
    localparam int XW  = DW + 2 * FRAC_BITS + 1;
    localparam int SRW = XW / 2;
    localparam int NW  = CW + FRAC_BITS + 3;
    localparam int DVW = CW + 1;
    localparam int QW  = 2 + DW + 2 * CW;
    localparam int SB1 = 2 + 2 * CW;
    localparam int SB2 = 4;

    // Front end to queue
    logic                 push;
    logic                 full;
    kind_t                push_kind;
    logic [DW-1:0]        push_dmag;
    logic signed [CW-1:0] push_a;
    logic signed [CW-1:0] push_b;

    // Queue to back end
    logic                 empty;
    logic                 pop;
    logic [QW-1:0]        head;
    logic [DW-1:0]        q_dmag;
    logic [SB1-1:0]       q_sb;

    // Back end pipeline
    logic                 en;
    logic                 sq_valid;
    logic [SRW-1:0]       sq_root;
    logic [SB1-1:0]       sq_sb;
    kind_t                sq_kind;
    logic signed [CW-1:0] sq_a;
    logic signed [CW-1:0] sq_b;

    logic signed [NW-1:0] b_ext;
    logic signed [NW-1:0] bs;
    logic signed [NW-1:0] s_ext;
    logic signed [NW-1:0] num_p;
    logic signed [NW-1:0] num_q;
    logic [CW-1:0]        a_mag;

    logic                 nm_valid_reg;
    logic [NW-1:0]        nm_p_reg;
    logic [NW-1:0]        nm_q_reg;
    logic [DVW-1:0]       nm_d_reg;
    logic [SB2-1:0]       nm_sb_reg;

    logic                 dv_valid;
    logic [NW-1:0]        quo_p;
    logic [NW-1:0]        quo_q;
    logic [SB2-1:0]       dv_sb;
    kind_t                dv_kind;
    logic signed [NW:0]   val_p;
    logic signed [NW:0]   val_q;
    logic signed [NW+1:0] neg_q;

    logic                 out_valid_reg;
    kind_t                kind_reg;
    root_t                r1_reg;
    root_t                i1_reg;
    root_t                r2_reg;
    root_t                i2_reg;

    qrs_front #(
        .COEF_WIDTH (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .coef_a    (coef_a),
        .coef_b    (coef_b),
        .coef_c    (coef_c),
        .push      (push),
        .full      (full),
        .push_kind (push_kind),
        .push_dmag (push_dmag),
        .push_a    (push_a),
        .push_b    (push_b)
    );

    qrs_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push),
        .wr_data ({push_kind, push_dmag, push_b, push_a}),
        .full    (full),
        .rd_en   (pop),
        .rd_data (head),
        .empty   (empty)
    );

    // Advance the back end whenever the output slot frees up
    assign en  = !out_valid_reg || !out_stall;
    assign pop = en && !empty;

    assign q_dmag = head[QW-3 -: DW];
    assign q_sb   = {head[QW-1 -: 2], head[2*CW-1:0]};

    qrs_sqrt #(
        .XW  (XW),
        .SBW (SB1)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pop),
        .x         (XW'(q_dmag) << (2 * FRAC_BITS)),
        .sb_in     (q_sb),
        .out_valid (sq_valid),
        .root      (sq_root),
        .sb_out    (sq_sb)
    );

    assign sq_kind = sq_sb[SB1-1 -: 2];
    assign sq_b    = sq_sb[2*CW-1:CW];
    assign sq_a    = sq_sb[CW-1:0];

    // Build the signed numerators from -b scaled and the root
    always_comb
    begin
        b_ext = NW'(sq_b);
        bs    = (-b_ext) <<< FRAC_BITS;
        s_ext = signed'(NW'(sq_root));
        if (sq_kind == KIND_COMPLEX)
        begin
            num_p = bs;
            num_q = s_ext;
        end
        else
        begin
            num_p = bs + s_ext;
            num_q = bs - s_ext;
        end
        a_mag = sq_a[CW-1] ? CW'(-sq_a) : CW'(sq_a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nm_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            nm_valid_reg <= sq_valid;
        end
    end

    // Register magnitudes and quotient signs
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nm_p_reg  <= num_p[NW-1] ? NW'(-num_p) : NW'(num_p);
            nm_q_reg  <= num_q[NW-1] ? NW'(-num_q) : NW'(num_q);
            nm_d_reg  <= {a_mag, 1'b0};
            nm_sb_reg <= {sq_kind, num_p[NW-1] ^ sq_a[CW-1], num_q[NW-1] ^ sq_a[CW-1]};
        end
    end

    qrs_div #(
        .NW  (NW),
        .DVW (DVW),
        .SBW (SB2)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (nm_valid_reg),
        .num_p     (nm_p_reg),
        .num_q     (nm_q_reg),
        .divisor   (nm_d_reg),
        .sb_in     (nm_sb_reg),
        .out_valid (dv_valid),
        .quo_p     (quo_p),
        .quo_q     (quo_q),
        .sb_out    (dv_sb)
    );

    // Apply quotient signs
    always_comb
    begin
        dv_kind = dv_sb[3:2];
        val_p   = dv_sb[1] ? -signed'({1'b0, quo_p}) : signed'({1'b0, quo_p});
        val_q   = dv_sb[0] ? -signed'({1'b0, quo_q}) : signed'({1'b0, quo_q});
        neg_q   = -(NW+2)'(val_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv_valid;
        end
    end

    // Place and clamp the root parts
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg <= dv_kind;
            case (dv_kind)
                KIND_LINEAR:
                begin
                    r1_reg <= '0;
                    i1_reg <= '0;
                    r2_reg <= '0;
                    i2_reg <= '0;
                end
                KIND_COMPLEX:
                begin
                    r1_reg <= sat_root(64'(val_p));
                    r2_reg <= sat_root(64'(val_p));
                    i1_reg <= sat_root(64'(val_q));
                    i2_reg <= sat_root(64'(neg_q));
                end
                default:
                begin
                    r1_reg <= sat_root(64'(val_p));
                    r2_reg <= sat_root(64'(val_q));
                    i1_reg <= '0;
                    i2_reg <= '0;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign root_kind   = kind_reg;
    assign first_real  = r1_reg;
    assign first_imag  = i1_reg;
    assign second_real = r2_reg;
    assign second_imag = i2_reg;

    // A zero leading coefficient gives all-zero root parts
    a_linear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && kind_reg == KIND_LINEAR |->
            r1_reg == '0 && i1_reg == '0 && r2_reg == '0 && i2_reg == '0)
        else $error("linear case with nonzero root");

    // Real roots carry no imaginary part
    a_real_imag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_DISTINCT || kind_reg == KIND_EQUAL) |->
            i1_reg == '0 && i2_reg == '0)
        else $error("real roots with imaginary part");

    // Equal roots and complex pairs share the real part
    a_shared_real: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_EQUAL || kind_reg == KIND_COMPLEX) |->
            r1_reg == r2_reg)
        else $error("real parts differ");

    // The queue never takes a word while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue overflow");

endmodule
